// ----- sv/nrmc_pkg.sv -----
// Package: shared constants, types and helper functions for the RMC sentence parser.
`default_nettype none
package nrmc_pkg;

    localparam int DEF_LINE_CAPACITY   = 128;
    localparam int DEF_FRACTION_DIGITS = 6;

    localparam int BYTE_W   = 8;
    localparam int COORD_W  = 48;
    localparam int MAG_W    = 47;
    localparam int POW10_W  = 30;
    localparam int TERM_W   = POW10_W + 4;
    localparam int SUM_W    = MAG_W + 5;
    localparam int FIELD_W  = 4;
    localparam int CHARS_W  = 3;
    localparam int TD_CHARS = 6;

    localparam logic [MAG_W-1:0] COORD_MAX = {MAG_W{1'b1}};

    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_POINT = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_A     = 8'h41;
    localparam logic [BYTE_W-1:0] CH_R     = 8'h52;
    localparam logic [BYTE_W-1:0] CH_M     = 8'h4D;
    localparam logic [BYTE_W-1:0] CH_C     = 8'h43;

    localparam int MIN_LINE_LEN = 6;
    localparam int TYPE_POS0    = 3;
    localparam int TYPE_POS1    = 4;
    localparam int TYPE_POS2    = 5;

    localparam logic [FIELD_W-1:0] FIELD_TIME    = 4'd1;
    localparam logic [FIELD_W-1:0] FIELD_STATUS  = 4'd2;
    localparam logic [FIELD_W-1:0] FIELD_LAT     = 4'd3;
    localparam logic [FIELD_W-1:0] FIELD_LAT_DIR = 4'd4;
    localparam logic [FIELD_W-1:0] FIELD_LON     = 4'd5;
    localparam logic [FIELD_W-1:0] FIELD_LON_DIR = 4'd6;
    localparam logic [FIELD_W-1:0] FIELD_DATE    = 4'd9;
    localparam logic [FIELD_W-1:0] FIELD_LAST    = 4'd10;

    typedef struct packed {
        logic clear;
        logic load;
        logic first;
    } coord_ctl_t;

    function automatic logic [POW10_W-1:0] pow10(input logic [3:0] n);
        logic [POW10_W-1:0] r;
        case (n)
            4'd0:    r = 30'd1;
            4'd1:    r = 30'd10;
            4'd2:    r = 30'd100;
            4'd3:    r = 30'd1000;
            4'd4:    r = 30'd10000;
            4'd5:    r = 30'd100000;
            4'd6:    r = 30'd1000000;
            4'd7:    r = 30'd10000000;
            4'd8:    r = 30'd100000000;
            4'd9:    r = 30'd1000000000;
            default: r = '0;
        endcase
        return r;
    endfunction

    // 10*(a-48)+(b-48) mod 256 equals 10*a+b-16 mod 256
    function automatic logic [BYTE_W-1:0] digit_pair(input logic [BYTE_W-1:0] a,
                                                     input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        r = {a[4:0], 3'b000} + {a[6:0], 1'b0} + b - 8'd16;
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- sv/nrmc_coord.sv -----
// Coordinate accumulator: builds a decimal value scaled by 10^FRACTION_DIGITS, saturating.
`default_nettype none
module nrmc_coord #(
    parameter int FRACTION_DIGITS = nrmc_pkg::DEF_FRACTION_DIGITS
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire nrmc_pkg::coord_ctl_t                ctl,
    input  wire logic [nrmc_pkg::BYTE_W-1:0]         char_in,
    output logic signed [nrmc_pkg::COORD_W-1:0]      value
);
    import nrmc_pkg::*;

    localparam int FC_W = $clog2(FRACTION_DIGITS + 1);

    logic [MAG_W-1:0] mag_reg, mag_next;
    logic             neg_reg, neg_next;
    logic             point_reg, point_next;
    logic             stop_reg, stop_next;
    logic [FC_W-1:0]  fc_reg, fc_next;

    logic             is_digit;
    logic [3:0]       digit;
    logic [3:0]       pow_idx;
    logic [TERM_W-1:0] term;
    logic [SUM_W-1:0] sum;
    logic             frac_full;

    always_comb begin
        is_digit  = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
        digit     = 4'(char_in - CH_ZERO);
        frac_full = (32'(fc_reg) >= FRACTION_DIGITS);
        if (point_reg) begin
            pow_idx = 4'(FRACTION_DIGITS) - 4'(fc_reg) - 4'd1;
        end else begin
            pow_idx = 4'(FRACTION_DIGITS);
        end
        term = TERM_W'(digit) * TERM_W'(pow10(pow_idx));
        if (point_reg) begin
            sum = SUM_W'(mag_reg) + SUM_W'(term);
        end else begin
            sum = {2'b00, mag_reg, 3'b000} + {4'b0000, mag_reg, 1'b0} + SUM_W'(term);
        end
    end

    always_comb begin
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        point_next = point_reg;
        stop_next  = stop_reg;
        fc_next    = fc_reg;
        if (ctl.clear) begin
            mag_next   = '0;
            neg_next   = 1'b0;
            point_next = 1'b0;
            stop_next  = 1'b0;
            fc_next    = '0;
        end else if (ctl.load && !stop_reg) begin
            if (ctl.first && char_in == CH_MINUS) begin
                neg_next = 1'b1;
            end else if (char_in == CH_POINT) begin
                point_next = 1'b1;
            end else if (!is_digit) begin
                stop_next = 1'b1;
            end else if (!(point_reg && frac_full)) begin
                if (point_reg) begin
                    fc_next = fc_reg + FC_W'(1);
                end
                if (sum > SUM_W'(COORD_MAX)) begin
                    mag_next = COORD_MAX;
                end else begin
                    mag_next = sum[MAG_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mag_reg   <= '0;
            neg_reg   <= 1'b0;
            point_reg <= 1'b0;
            stop_reg  <= 1'b0;
            fc_reg    <= '0;
        end else begin
            mag_reg   <= mag_next;
            neg_reg   <= neg_next;
            point_reg <= point_next;
            stop_reg  <= stop_next;
            fc_reg    <= fc_next;
        end
    end

    always_comb begin
        if (neg_reg) begin
            value = -$signed({1'b0, mag_reg});
        end else begin
            value = $signed({1'b0, mag_reg});
        end
    end

endmodule
`default_nettype wire

// ----- sv/nmea_rmc_sentence_parser.sv -----
// Top level: byte-wise NMEA RMC sentence parser with registered result output.
// Result: registered on m_* in the cycle after the CR or LF transaction that ends its line.
// Throughput: one byte per cycle; s_ready drops only while a result waits and m_ready is low.
// Each byte updates small running field registers; no line buffer is kept.
// Reset: synchronous, active low; clears parse state and the output valid.
`default_nettype none
module nmea_rmc_sentence_parser #(
    parameter int LINE_CAPACITY   = nrmc_pkg::DEF_LINE_CAPACITY,
    parameter int FRACTION_DIGITS = nrmc_pkg::DEF_FRACTION_DIGITS
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic [7:0]                           s_rx_data,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic [7:0]                                m_hour,
    output logic [7:0]                                m_minute,
    output logic [7:0]                                m_second,
    output logic                                      m_fix_valid,
    output logic signed [nrmc_pkg::COORD_W-1:0]       m_latitude_micro,
    output logic [7:0]                                m_latitude_dir,
    output logic signed [nrmc_pkg::COORD_W-1:0]       m_longitude_micro,
    output logic [7:0]                                m_longitude_dir,
    output logic [7:0]                                m_day,
    output logic [7:0]                                m_month,
    output logic [7:0]                                m_year
);
    import nrmc_pkg::*;

    localparam int POS_W = $clog2(LINE_CAPACITY);

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [FIELD_W-1:0] field_reg, field_next;
    logic [CHARS_W-1:0] chars_reg, chars_next;
    logic [2:0]         type_reg, type_next;
    logic               ended_reg, ended_next;
    logic               time_full_reg, time_full_next;
    logic               date_full_reg, date_full_next;
    logic               status_reg, status_next;
    logic [BYTE_W-1:0]  lat_dir_reg, lat_dir_next;
    logic [BYTE_W-1:0]  lon_dir_reg, lon_dir_next;
    logic [BYTE_W-1:0]  time_chars_reg [TD_CHARS];
    logic [BYTE_W-1:0]  time_chars_next [TD_CHARS];
    logic [BYTE_W-1:0]  date_chars_reg [TD_CHARS];
    logic [BYTE_W-1:0]  date_chars_next [TD_CHARS];
    logic               m_valid_reg, m_valid_next;

    logic               accept;
    logic               is_eol;
    logic               emit;
    logic               line_clear;
    logic               parse_char;
    logic               first_char;
    coord_ctl_t         lat_ctl, lon_ctl;
    logic signed [COORD_W-1:0] lat_value, lon_value;

    nrmc_coord #(
        .FRACTION_DIGITS(FRACTION_DIGITS)
    ) u_lat (
        .aclk   (aclk),
        .aresetn(aresetn),
        .ctl    (lat_ctl),
        .char_in(s_rx_data),
        .value  (lat_value)
    );

    nrmc_coord #(
        .FRACTION_DIGITS(FRACTION_DIGITS)
    ) u_lon (
        .aclk   (aclk),
        .aresetn(aresetn),
        .ctl    (lon_ctl),
        .char_in(s_rx_data),
        .value  (lon_value)
    );

    assign s_ready = !m_valid_reg || m_ready;
    assign m_valid = m_valid_reg;
    assign accept  = s_valid && s_ready;
    assign is_eol  = (s_rx_data == CH_LF) || (s_rx_data == CH_CR);
    assign emit    = accept && is_eol && (pos_reg > POS_W'(MIN_LINE_LEN)) && (&type_reg);

    always_comb begin
        pos_next       = pos_reg;
        field_next     = field_reg;
        chars_next     = chars_reg;
        type_next      = type_reg;
        ended_next     = ended_reg;
        time_full_next = time_full_reg;
        date_full_next = date_full_reg;
        status_next    = status_reg;
        lat_dir_next   = lat_dir_reg;
        lon_dir_next   = lon_dir_reg;
        time_chars_next = time_chars_reg;
        date_chars_next = date_chars_reg;
        line_clear     = 1'b0;
        parse_char     = 1'b0;
        first_char     = (chars_reg == '0);

        if (accept) begin
            if (is_eol || pos_reg == POS_W'(LINE_CAPACITY - 1)) begin
                line_clear = 1'b1;
                pos_next   = '0;
            end else begin
                pos_next = pos_reg + POS_W'(1);
                if (pos_reg == POS_W'(TYPE_POS0)) begin
                    type_next[0] = (s_rx_data == CH_R);
                end
                if (pos_reg == POS_W'(TYPE_POS1)) begin
                    type_next[1] = (s_rx_data == CH_M);
                end
                if (pos_reg == POS_W'(TYPE_POS2)) begin
                    type_next[2] = (s_rx_data == CH_C);
                end
                if (!ended_reg) begin
                    if (s_rx_data == CH_NUL) begin
                        ended_next = 1'b1;
                    end else if (s_rx_data == CH_COMMA) begin
                        chars_next = '0;
                        if (field_reg != FIELD_LAST) begin
                            field_next = field_reg + FIELD_W'(1);
                        end
                    end else begin
                        parse_char = 1'b1;
                        if (chars_reg < CHARS_W'(TD_CHARS)) begin
                            chars_next = chars_reg + CHARS_W'(1);
                        end
                        case (field_reg)
                            FIELD_TIME: begin
                                if (chars_reg < CHARS_W'(TD_CHARS)) begin
                                    time_chars_next[chars_reg] = s_rx_data;
                                end
                                if (chars_reg == CHARS_W'(TD_CHARS - 1)) begin
                                    time_full_next = 1'b1;
                                end
                            end
                            FIELD_STATUS: begin
                                if (first_char) begin
                                    status_next = (s_rx_data == CH_A);
                                end
                            end
                            FIELD_LAT_DIR: begin
                                if (first_char) begin
                                    lat_dir_next = s_rx_data;
                                end
                            end
                            FIELD_LON_DIR: begin
                                if (first_char) begin
                                    lon_dir_next = s_rx_data;
                                end
                            end
                            FIELD_DATE: begin
                                if (chars_reg < CHARS_W'(TD_CHARS)) begin
                                    date_chars_next[chars_reg] = s_rx_data;
                                end
                                if (chars_reg == CHARS_W'(TD_CHARS - 1)) begin
                                    date_full_next = 1'b1;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
        end

        if (line_clear) begin
            field_next     = '0;
            chars_next     = '0;
            type_next      = '0;
            ended_next     = 1'b0;
            time_full_next = 1'b0;
            date_full_next = 1'b0;
            status_next    = 1'b0;
            lat_dir_next   = '0;
            lon_dir_next   = '0;
        end

        lat_ctl.clear = line_clear;
        lat_ctl.load  = parse_char && (field_reg == FIELD_LAT);
        lat_ctl.first = first_char;
        lon_ctl.clear = line_clear;
        lon_ctl.load  = parse_char && (field_reg == FIELD_LON);
        lon_ctl.first = first_char;
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            field_reg     <= '0;
            chars_reg     <= '0;
            type_reg      <= '0;
            ended_reg     <= 1'b0;
            time_full_reg <= 1'b0;
            date_full_reg <= 1'b0;
            status_reg    <= 1'b0;
            lat_dir_reg   <= '0;
            lon_dir_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            field_reg     <= field_next;
            chars_reg     <= chars_next;
            type_reg      <= type_next;
            ended_reg     <= ended_next;
            time_full_reg <= time_full_next;
            date_full_reg <= date_full_next;
            status_reg    <= status_next;
            lat_dir_reg   <= lat_dir_next;
            lon_dir_reg   <= lon_dir_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        time_chars_reg <= time_chars_next;
        date_chars_reg <= date_chars_next;
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            if (time_full_reg) begin
                m_hour   <= digit_pair(time_chars_reg[0], time_chars_reg[1]);
                m_minute <= digit_pair(time_chars_reg[2], time_chars_reg[3]);
                m_second <= digit_pair(time_chars_reg[4], time_chars_reg[5]);
            end else begin
                m_hour   <= '0;
                m_minute <= '0;
                m_second <= '0;
            end
            if (date_full_reg) begin
                m_day   <= digit_pair(date_chars_reg[0], date_chars_reg[1]);
                m_month <= digit_pair(date_chars_reg[2], date_chars_reg[3]);
                m_year  <= digit_pair(date_chars_reg[4], date_chars_reg[5]);
            end else begin
                m_day   <= '0;
                m_month <= '0;
                m_year  <= '0;
            end
            m_fix_valid       <= status_reg;
            m_latitude_micro  <= lat_value;
            m_latitude_dir    <= lat_dir_reg;
            m_longitude_micro <= lon_value;
            m_longitude_dir   <= lon_dir_reg;
        end
    end

endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
// Testbench for the NMEA RMC sentence parser: byte stream stimulus, line-level predictor, result checks.
`timescale 1ns / 100ps
module tb;
    import nrmc_pkg::*;

    localparam int LINE_CAP     = DEF_LINE_CAPACITY;
    localparam int NUM_PHASES   = 4;
    localparam int PHASE_BYTES  = 150;
    localparam int LONG_HOLD    = 400;
    localparam int MAX_REPORTS  = 100;
    localparam int CYCLE_LIMIT  = 600000;

    typedef struct packed {
        bit [7:0]         hour;
        bit [7:0]         minute;
        bit [7:0]         second;
        bit               fix_valid;
        bit [COORD_W-1:0] latitude;
        bit [7:0]         lat_dir;
        bit [COORD_W-1:0] longitude;
        bit [7:0]         lon_dir;
        bit [7:0]         day;
        bit [7:0]         month;
        bit [7:0]         year;
    } rmc_fix_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [7:0]                s_rx_data = 8'h00;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [7:0]                m_hour;
    logic [7:0]                m_minute;
    logic [7:0]                m_second;
    logic                      m_fix_valid;
    logic signed [COORD_W-1:0] m_latitude_micro;
    logic [7:0]                m_latitude_dir;
    logic signed [COORD_W-1:0] m_longitude_micro;
    logic [7:0]                m_longitude_dir;
    logic [7:0]                m_day;
    logic [7:0]                m_month;
    logic [7:0]                m_year;

    bit [7:0] rx_stream[$];
    rmc_fix_t expected_fixes[$];
    rmc_fix_t fix_want;
    bit [7:0] line_buf [0:LINE_CAP-1];
    int       line_len = 0;
    int       gen_col = 0;
    int       bytes_queued = 0;
    int       bytes_accepted = 0;
    int       fixes_checked = 0;
    int       mismatches = 0;
    int       tx_idle_pct = 0;
    int       rx_stall_pct = 0;
    bit       hold_arm = 1'b0;
    bit       hold_done = 1'b0;
    int       hold_left = 0;
    int       cycle_cnt = 0;

    nmea_rmc_sentence_parser u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_rx_data         (s_rx_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_hour            (m_hour),
        .m_minute          (m_minute),
        .m_second          (m_second),
        .m_fix_valid       (m_fix_valid),
        .m_latitude_micro  (m_latitude_micro),
        .m_latitude_dir    (m_latitude_dir),
        .m_longitude_micro (m_longitude_micro),
        .m_longitude_dir   (m_longitude_dir),
        .m_day             (m_day),
        .m_month           (m_month),
        .m_year            (m_year)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic bit [7:0] ascii_pair(input int pos);
        return 8'((int'(line_buf[pos]) - int'(CH_ZERO)) * 10
                  + int'(line_buf[pos+1]) - int'(CH_ZERO));
    endfunction

    function automatic bit [COORD_W-1:0] coord_micro(input int first, input int n);
        int        i;
        int        frac;
        bit        neg;
        bit        point;
        bit        sat;
        bit        done;
        bit [63:0] mag;
        bit [7:0]  c;
        i = 0;
        frac = 0;
        neg = 1'b0;
        point = 1'b0;
        sat = 1'b0;
        done = 1'b0;
        mag = '0;
        if (n > 0 && line_buf[first] == CH_MINUS) begin
            neg = 1'b1;
            i = 1;
        end
        while (i < n && !done) begin
            c = line_buf[first+i];
            if (c == CH_POINT) begin
                point = 1'b1;
            end else if (c < CH_ZERO || c > CH_NINE) begin
                done = 1'b1;
            end else if (!(point && frac >= DEF_FRACTION_DIGITS)) begin
                if (point) frac++;
                if (!sat) begin
                    mag = mag * 10 + (c - CH_ZERO);
                    if (mag > COORD_MAX) sat = 1'b1;
                end
            end
            i++;
        end
        while (frac < DEF_FRACTION_DIGITS) begin
            if (!sat) begin
                mag = mag * 10;
                if (mag > COORD_MAX) sat = 1'b1;
            end
            frac++;
        end
        if (sat) mag = COORD_MAX;
        if (neg) mag = ~mag + 1;
        return mag[COORD_W-1:0];
    endfunction

    function automatic rmc_fix_t parse_rmc_line(input int len);
        rmc_fix_t f;
        int       text_len;
        int       start;
        int       stop;
        int       n;
        int       fld;
        bit       last;
        f = '0;
        text_len = 0;
        start = 0;
        fld = 0;
        last = 1'b0;
        while (text_len < len && line_buf[text_len] != CH_NUL) text_len++;
        while (!last) begin
            stop = start;
            while (stop < text_len && line_buf[stop] != CH_COMMA) stop++;
            n = stop - start;
            if (n > 0) begin
                case (fld)
                    FIELD_TIME: begin
                        if (n >= TD_CHARS) begin
                            f.hour   = ascii_pair(start);
                            f.minute = ascii_pair(start + 2);
                            f.second = ascii_pair(start + 4);
                        end
                    end
                    FIELD_STATUS:  f.fix_valid = (line_buf[start] == CH_A);
                    FIELD_LAT:     f.latitude = coord_micro(start, n);
                    FIELD_LAT_DIR: f.lat_dir = line_buf[start];
                    FIELD_LON:     f.longitude = coord_micro(start, n);
                    FIELD_LON_DIR: f.lon_dir = line_buf[start];
                    FIELD_DATE: begin
                        if (n >= TD_CHARS) begin
                            f.day   = ascii_pair(start);
                            f.month = ascii_pair(start + 2);
                            f.year  = ascii_pair(start + 4);
                        end
                    end
                    default: ;
                endcase
            end
            fld++;
            if (stop >= text_len) last = 1'b1;
            else start = stop + 1;
        end
        return f;
    endfunction

    task automatic track_rx_byte(input bit [7:0] b);
        if (b == CH_LF || b == CH_CR) begin
            if (line_len > MIN_LINE_LEN && line_len < LINE_CAP &&
                line_buf[TYPE_POS0] == CH_R && line_buf[TYPE_POS1] == CH_M &&
                line_buf[TYPE_POS2] == CH_C)
                expected_fixes.push_back(parse_rmc_line(line_len));
            line_len = 0;
        end else if (line_len < LINE_CAP - 1) begin
            line_buf[line_len] = b;
            line_len++;
        end else begin
            line_len = 0;
        end
    endtask

    task automatic check_field(input string name, input bit [COORD_W-1:0] want,
                               input logic [COORD_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    task automatic push_byte(input bit [7:0] b);
        rx_stream.push_back(b);
        bytes_queued++;
        if (b == CH_CR || b == CH_LF) gen_col = 0;
        else gen_col++;
    endtask

    task automatic push_str(input string s);
        int i;
        for (i = 0; i < s.len(); i++) push_byte(s[i]);
    endtask

    task automatic push_digits(input int n);
        repeat (n) push_byte(CH_ZERO + 8'($urandom_range(9)));
    endtask

    function automatic bit [7:0] rand_field_char();
        bit [7:0] c;
        do c = 8'($urandom_range(1, 255));
        while (c == CH_LF || c == CH_CR || c == CH_COMMA);
        return c;
    endfunction

    task automatic push_clock_field();
        int sel;
        sel = $urandom_range(9);
        if (sel < 6) begin
            push_digits(TD_CHARS);
            if (sel < 3) begin
                push_byte(CH_POINT);
                push_digits(2);
            end
        end else if (sel == 6) begin
            push_digits($urandom_range(1, 5));
        end else if (sel == 7) begin
            repeat ($urandom_range(6, 8)) push_byte(rand_field_char());
        end
    endtask

    task automatic push_status();
        case ($urandom_range(7))
            0, 1, 2: push_byte(CH_A);
            3, 4:    push_str("V");
            5:       push_byte(rand_field_char());
            6: begin
                push_byte(CH_NUL);
                push_byte(CH_A);
            end
            default: ;
        endcase
    endtask

    task automatic push_dir(input bit [7:0] a, input bit [7:0] b);
        case ($urandom_range(7))
            0, 1, 2: push_byte(a);
            3, 4:    push_byte(b);
            5:       push_byte(rand_field_char());
            6: begin
                push_byte(rand_field_char());
                push_byte(rand_field_char());
            end
            default: ;
        endcase
    endtask

    task automatic push_coord();
        int sel;
        sel = $urandom_range(19);
        if (sel != 0) begin
            if (sel < 4) push_byte(CH_MINUS);
            push_digits(sel == 19 ? $urandom_range(10, 22) : $urandom_range(1, 5));
            if (sel != 5) begin
                push_byte(CH_POINT);
                push_digits(sel > 15 ? $urandom_range(7, 12) : $urandom_range(0, 6));
            end
            if (sel == 6) begin
                push_byte(CH_POINT);
                push_digits(2);
            end
            if (sel == 7) begin
                push_byte(rand_field_char());
                push_digits(2);
            end
        end
    endtask

    task automatic push_random_line();
        int kind;
        int nf;
        int k;
        kind = $urandom_range(99);
        if (kind < 10) begin
            repeat ($urandom_range(1, 40)) push_byte(8'($urandom_range(255)));
        end else begin
            push_str(kind < 55 ? "$GP" : "$GN");
            push_str(kind < 18 ? "GGA" : "RMC");
            nf = ($urandom_range(7) == 0) ? $urandom_range(0, 9) : 10 + $urandom_range(0, 3);
            for (k = 1; k <= nf; k++) begin
                push_byte(CH_COMMA);
                case (k)
                    FIELD_TIME, FIELD_DATE:   push_clock_field();
                    FIELD_STATUS:             push_status();
                    FIELD_LAT, FIELD_LON:     push_coord();
                    FIELD_LAT_DIR:            push_dir("N", "S");
                    FIELD_LON_DIR:            push_dir("E", "W");
                    default:                  push_digits($urandom_range(0, 4));
                endcase
            end
            if ($urandom_range(24) == 0)
                repeat ($urandom_range(50, 130)) push_byte(rand_field_char());
            case ($urandom_range(2))
                0: push_byte(CH_CR);
                1: push_byte(CH_LF);
                default: begin
                    push_byte(CH_CR);
                    push_byte(CH_LF);
                end
            endcase
        end
    endtask

    task automatic push_corner_lines();
        push_str("$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W*6A");
        push_byte(CH_CR);
        push_byte(CH_LF);
        push_str("$GNRMC,235959.99,V,-0.5,S,-17959.9999999,W,,,311299,,");
        push_byte(CH_CR);
        push_str("$GPRMC,,,,,,,,,,");
        push_byte(CH_LF);
        push_str("$GPRMC,12345,A,1,N,2,E,,,12345");
        push_byte(CH_CR);
        push_str("$GPRMC,ab:cd~,VA,12a34,NS,--5,EW,,,zz{|}~");
        push_byte(CH_LF);
        push_str("$GPRMC,000000,A,99999999999999999999,N,140737488.355328,E,,,000000");
        push_byte(CH_CR);
        push_str("$GPRMC,999999,A,140737488.355327,S,-140737488.355327,W,,,999999");
        push_byte(CH_CR);
        push_str("$GPRMC,010203,A,-,N,1.2.3,E,7,8,010203");
        push_byte(CH_CR);
        push_str("$GPRMC,010203,A,.,N,,E,,,0102");
        push_byte(CH_LF);
        push_str("$GPRMC,010203,A,12");
        push_byte(CH_NUL);
        push_str("34,N,5,E,,,010203");
        push_byte(CH_CR);
        push_str("$");
        push_byte(CH_NUL);
        push_str("PRMC,111111,A,1,N,1,E,,,111111");
        push_byte(CH_CR);
        push_str("$GPRMC");
        push_byte(CH_CR);
        push_str("$GPRMC,");
        push_byte(CH_LF);
        push_str("$GPGGA,123519,4807.038,N,01131.000,E");
        push_byte(CH_CR);
        push_byte(CH_LF);
        push_byte(CH_LF);
        push_byte(CH_CR);
        push_str("$GPRMC,120000,A,1.0,");
        push_byte(8'hFF);
        push_str(",2.0,");
        push_byte(8'h80);
        push_str(",,,010100");
        push_byte(CH_CR);
        push_str("$GPRMC,081836,A,3751.65,S,14507.36,E,000.0,360.0,130998,011.3,E,");
        while (gen_col < LINE_CAP - 1) push_byte("9");
        push_byte(CH_CR);
        repeat (LINE_CAP - 1) push_byte("x");
        push_byte("$");
        push_str("$GNRMC,225446,A,4916.45,N,12311.12,W,000.5,054.7,191194,020.3,E");
        push_byte(CH_CR);
        push_byte(CH_LF);
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (bytes_accepted != bytes_queued || expected_fixes.size() != 0);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (rx_stream.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                s_valid   <= 1'b1;
                s_rx_data <= rx_stream.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_arm && !hold_done) begin
            m_ready   <= 1'b0;
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                track_rx_byte(s_rx_data);
                bytes_accepted++;
            end
            if (m_valid && m_ready) begin
                if (expected_fixes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: result transaction with none expected", $time);
                end else begin
                    fix_want = expected_fixes.pop_front();
                    check_field("hour", fix_want.hour, m_hour);
                    check_field("minute", fix_want.minute, m_minute);
                    check_field("second", fix_want.second, m_second);
                    check_field("fix_valid", fix_want.fix_valid, m_fix_valid);
                    check_field("latitude_micro", fix_want.latitude, m_latitude_micro);
                    check_field("latitude_dir", fix_want.lat_dir, m_latitude_dir);
                    check_field("longitude_micro", fix_want.longitude, m_longitude_micro);
                    check_field("longitude_dir", fix_want.lon_dir, m_longitude_dir);
                    check_field("day", fix_want.day, m_day);
                    check_field("month", fix_want.month, m_month);
                    check_field("year", fix_want.year, m_year);
                    fixes_checked++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int phase;
        int quota;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        hold_arm = 1'b1;
        push_corner_lines();
        wait_drained();
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase % 4)
                0: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    tx_idle_pct  = 86;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 86;
                end
                default: begin
                    tx_idle_pct  = 19;
                    rx_stall_pct = 19;
                end
            endcase
            quota = bytes_queued + PHASE_BYTES;
            while (bytes_queued < quota) push_random_line();
            wait_drained();
        end
        repeat (8) @(posedge aclk);
        $display("Sent %0d bytes and compared %0d RMC fixes, %0d field mismatches.",
                 bytes_accepted, fixes_checked, mismatches);
        $display("Covered corner sentences, random and broken lines, four pacing modes"
                 , " and one long output stall.");
        if (mismatches == 0 && expected_fixes.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- files.f -----
sv/nrmc_pkg.sv
sv/nrmc_coord.sv
sv/nmea_rmc_sentence_parser.sv
tb/sv/tb.sv
